// File: sv/huffman_code_length_builder_macros.svh
// ----------------------------------------------------------------------------
// Huffman code length builder assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_LENGTH_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_LENGTH_BUILDER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define HCLB_ASSERT_SAME(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HCLB_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/hclb_pkg.sv
// ----------------------------------------------------------------------------
// hclb_pkg
// Types, constants and state encodings of the Huffman code length builder.
// ----------------------------------------------------------------------------
package hclb_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int MAX_LEVEL   = 24;

   localparam int NSYM       = 257;
   localparam int EOB_SYM    = 256;
   localparam int HEAP_SLOTS = 258;
   localparam int NODE_SLOTS = 513;

   localparam int SYM_AW   = $clog2(NSYM);
   localparam int HEAP_AW  = $clog2(HEAP_SLOTS);
   localparam int NODE_AW  = $clog2(NODE_SLOTS);
   localparam int DEPTH_W  = 9;
   localparam int LEVEL_W  = $clog2(MAX_LEVEL + 1);
   localparam int LC_W     = 9;
   localparam int WEIGHT_W = COUNT_WIDTH + 10;
   localparam int PROD_W   = DEPTH_W + COUNT_WIDTH;
   localparam int BITS_W   = PROD_W + 9;
   localparam int ANSWER_W = 40;

   localparam logic [2:0] KIND_DATA   = 3'd0;
   localparam logic [2:0] KIND_BUILD  = 3'd1;
   localparam logic [2:0] KIND_QLEN   = 3'd2;
   localparam logic [2:0] KIND_QLEVEL = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   localparam logic [1:0] CSR_LIMIT_ENABLE = 2'd0;
   localparam logic [1:0] CSR_BYTE_LIMIT   = 2'd1;

   typedef struct packed {
      logic [2:0] kind;
      logic [8:0] value;
   } req_type;

   typedef struct packed {
      logic [ANSWER_W-1:0] answer;
      logic [8:0]          max_level;
      logic [8:0]          distinct;
      logic [31:0]         total_bytes;
      logic                overflow;
   } rsp_type;

   typedef struct packed {
      logic [WEIGHT_W-1:0] weight;
      logic [NODE_AW-1:0]  node;
   } heap_entry_type;

   typedef struct packed {
      logic               rd_en;
      logic [HEAP_AW-1:0] rd_addr;
      logic               wr_en;
      logic [HEAP_AW-1:0] wr_addr;
      heap_entry_type     wr_data;
   } heap_req_type;

   typedef enum logic [2:0] {
      SF_IDLE,
      SF_RD,
      SF_LDW,
      SF_CHK,
      SF_K0,
      SF_K1,
      SF_DEC
   } sift_state_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DATA_WR,
      ST_QLEN,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_HEAPIFY,
      ST_HEAPIFY_WAIT,
      ST_MERGE,
      ST_MERGE_FIRST,
      ST_MERGE_LAST,
      ST_SIFT_A,
      ST_MERGE_RD,
      ST_MERGE_JOIN,
      ST_SIFT_B,
      ST_DEPTH_RD,
      ST_DEPTH_PAR,
      ST_DEPTH_GET,
      ST_DEPTH_WR,
      ST_DEPTH_MUL,
      ST_DEPTH_ACC,
      ST_SIZE,
      ST_RESP
   } state_type;

endpackage

// File: sv/huffman_code_length_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_length_builder
// Byte histogram, heap-based Huffman tree build and code length queries.
// ----------------------------------------------------------------------------
// One item at a time. After reset, and for a clear item, a pass zeroes the
// histogram and the code length entries of the depth RAM; no item is taken
// meanwhile. A data byte does a histogram read-modify-write. A length query
// reads the depth RAM before the result is handed over; a level query hands
// it over directly. A build is bounded by the heap RAM, which the top level
// shares with one sift-down unit: the load of the heap slots, then the sifts
// (heapify, then two sifts per merge with the merge reads and writes around
// them), then the depth walk over every tree node, then the size step and the
// response. Configuration writes are taken any time.
// ----------------------------------------------------------------------------
`include "huffman_code_length_builder_macros.svh"

module huffman_code_length_builder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hclb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hclb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int SYM_AW   = hclb_pkg::SYM_AW;
   localparam int HEAP_AW  = hclb_pkg::HEAP_AW;
   localparam int NODE_AW  = hclb_pkg::NODE_AW;
   localparam int DEPTH_W  = hclb_pkg::DEPTH_W;
   localparam int LEVEL_W  = hclb_pkg::LEVEL_W;
   localparam int LC_W     = hclb_pkg::LC_W;
   localparam int WEIGHT_W = hclb_pkg::WEIGHT_W;
   localparam int PROD_W   = hclb_pkg::PROD_W;
   localparam int BITS_W   = hclb_pkg::BITS_W;
   localparam int ANSWER_W = hclb_pkg::ANSWER_W;
   localparam int CW       = hclb_pkg::COUNT_WIDTH;
   localparam int SIZE_W   = BITS_W - 3;

   hclb_pkg::state_type      state_ff, state_in;
   logic [NODE_AW-1:0]       idx_ff, idx_in;
   logic [HEAP_AW-1:0]       used_ff, used_in;
   logic [NODE_AW-1:0]       next_ff, next_in;
   logic [WEIGHT_W-1:0]      first_ff, first_in;
   logic [DEPTH_W-1:0]       dval_ff, dval_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [BITS_W-1:0]        bits_ff, bits_in;
   logic [7:0]               byte_ff, byte_in;
   logic [ANSWER_W-1:0]      ans_ff, ans_in;
   logic [31:0]              byte_total_ff, byte_total_in;
   logic [8:0]               maxlev_ff, maxlev_in;
   logic [8:0]               distinct_ff, distinct_in;
   logic                     ovf_ff, ovf_in;
   logic [LC_W-1:0]          lc_ff [hclb_pkg::MAX_LEVEL+1];
   logic [LC_W-1:0]          lc_in [hclb_pkg::MAX_LEVEL+1];
   logic                     limit_enable_ff;
   logic [31:0]              byte_limit_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   hclb_pkg::rsp_type        rsp_data_ff, rsp_data_in;

   logic                     hist_we, hist_re;
   logic [SYM_AW-1:0]        hist_wa, hist_ra;
   logic [CW-1:0]            hist_wd, hist_rd;
   logic                     par_we, par_re;
   logic [NODE_AW-1:0]       par_wa, par_ra, par_wd, par_rd;
   logic                     dep_we, dep_re;
   logic [NODE_AW-1:0]       dep_wa, dep_ra;
   logic [DEPTH_W-1:0]       dep_wd, dep_rd;

   hclb_pkg::heap_req_type   top_heap_req, sift_heap_req, heap_req;
   hclb_pkg::heap_entry_type heap_rd;
   logic                     sift_start, sift_done, sift_sel;
   logic [HEAP_AW-1:0]       sift_pos, sift_used;

   logic                     req_accept;
   logic [HEAP_AW-1:0]       used_load;
   logic [WEIGHT_W-1:0]      load_w;
   logic [SIZE_W-1:0]        size_full;

   assign req_stall  = (state_ff != hclb_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign sift_sel = (state_ff == hclb_pkg::ST_HEAPIFY_WAIT) ||
                     (state_ff == hclb_pkg::ST_SIFT_A) ||
                     (state_ff == hclb_pkg::ST_SIFT_B);
   assign heap_req = sift_sel ? sift_heap_req : top_heap_req;

   // end symbol has fixed weight one; every count is doubled
   assign load_w    = (idx_ff == NODE_AW'(hclb_pkg::EOB_SYM)) ? WEIGHT_W'(1) :
                      WEIGHT_W'({hist_rd, 1'b0});
   assign used_load = (load_w != '0) ? used_ff + 1'b1 : used_ff;
   assign size_full = bits_ff[BITS_W-1:3] + SIZE_W'(|bits_ff[2:0]);

   hclb_ram #(.WIDTH(CW), .DEPTH(hclb_pkg::NSYM)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_wa),
      .wr_data (hist_wd),
      .rd_en   (hist_re),
      .rd_addr (hist_ra),
      .rd_data (hist_rd)
   );

   hclb_ram #(.WIDTH($bits(hclb_pkg::heap_entry_type)), .DEPTH(hclb_pkg::HEAP_SLOTS)) u_heap (
      .clock   (clock),
      .wr_en   (heap_req.wr_en),
      .wr_addr (heap_req.wr_addr),
      .wr_data (heap_req.wr_data),
      .rd_en   (heap_req.rd_en),
      .rd_addr (heap_req.rd_addr),
      .rd_data (heap_rd)
   );

   hclb_ram #(.WIDTH(NODE_AW), .DEPTH(hclb_pkg::NODE_SLOTS)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_wa),
      .wr_data (par_wd),
      .rd_en   (par_re),
      .rd_addr (par_ra),
      .rd_data (par_rd)
   );

   // depth of every tree node; entries below the symbol count are the code lengths
   hclb_ram #(.WIDTH(DEPTH_W), .DEPTH(hclb_pkg::NODE_SLOTS)) u_depth (
      .clock   (clock),
      .wr_en   (dep_we),
      .wr_addr (dep_wa),
      .wr_data (dep_wd),
      .rd_en   (dep_re),
      .rd_addr (dep_ra),
      .rd_data (dep_rd)
   );

   hclb_sift u_sift (
      .clock    (clock),
      .reset    (reset),
      .start    (sift_start),
      .pos      (sift_pos),
      .used     (sift_used),
      .done     (sift_done),
      .heap_req (sift_heap_req),
      .heap_rd  (heap_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         byte_limit_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hclb_pkg::CSR_LIMIT_ENABLE: limit_enable_ff <= csr_wdata[0];
            hclb_pkg::CSR_BYTE_LIMIT:   byte_limit_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= hclb_pkg::ST_CLEAR;
         idx_ff        <= '0;
         byte_total_ff <= '0;
         maxlev_ff     <= '0;
         distinct_ff   <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i <= hclb_pkg::MAX_LEVEL; i++) begin
            lc_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         byte_total_ff <= byte_total_in;
         maxlev_ff     <= maxlev_in;
         distinct_ff   <= distinct_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         lc_ff         <= lc_in;
      end
   end

   always_ff @(posedge clock) begin
      used_ff     <= used_in;
      next_ff     <= next_in;
      first_ff    <= first_in;
      dval_ff     <= dval_in;
      prod_ff     <= prod_in;
      bits_ff     <= bits_in;
      byte_ff     <= byte_in;
      ans_ff      <= ans_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      used_in       = used_ff;
      next_in       = next_ff;
      first_in      = first_ff;
      dval_in       = dval_ff;
      prod_in       = prod_ff;
      bits_in       = bits_ff;
      byte_in       = byte_ff;
      ans_in        = ans_ff;
      byte_total_in = byte_total_ff;
      maxlev_in     = maxlev_ff;
      distinct_in   = distinct_ff;
      ovf_in        = ovf_ff;
      lc_in         = lc_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      hist_we = 1'b0;
      hist_wa = idx_ff[SYM_AW-1:0];
      hist_wd = '0;
      hist_re = 1'b0;
      hist_ra = idx_ff[SYM_AW-1:0];
      par_we  = 1'b0;
      par_wa  = idx_ff;
      par_wd  = '0;
      par_re  = 1'b0;
      par_ra  = idx_ff;
      dep_we  = 1'b0;
      dep_wa  = idx_ff;
      dep_wd  = '0;
      dep_re  = 1'b0;
      dep_ra  = idx_ff;

      top_heap_req = '0;
      sift_start   = 1'b0;
      sift_pos     = HEAP_AW'(1);
      sift_used    = used_ff;

      unique case (state_ff)
         hclb_pkg::ST_CLEAR: begin
            hist_we = 1'b1;
            dep_we  = 1'b1;
            if (idx_ff == NODE_AW'(hclb_pkg::NSYM - 1)) begin
               state_in = hclb_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         hclb_pkg::ST_IDLE: begin
            if (req_accept) begin
               case (req_data.kind)
                  hclb_pkg::KIND_DATA: begin
                     if (!(limit_enable_ff && byte_total_ff >= byte_limit_ff)) begin
                        if (byte_total_ff == '1) begin
                           ovf_in = 1'b1;
                        end else begin
                           byte_total_in = byte_total_ff + 1'b1;
                        end
                        byte_in  = req_data.value[7:0];
                        hist_re  = 1'b1;
                        hist_ra  = SYM_AW'(req_data.value[7:0]);
                        state_in = hclb_pkg::ST_DATA_WR;
                     end
                  end
                  hclb_pkg::KIND_BUILD: begin
                     idx_in   = NODE_AW'(hclb_pkg::EOB_SYM);
                     used_in  = '0;
                     state_in = hclb_pkg::ST_LOAD_RD;
                  end
                  hclb_pkg::KIND_QLEN: begin
                     if (req_data.value <= 9'(hclb_pkg::EOB_SYM)) begin
                        dep_re   = 1'b1;
                        dep_ra   = NODE_AW'(req_data.value);
                        state_in = hclb_pkg::ST_QLEN;
                     end else begin
                        ans_in   = '0;
                        state_in = hclb_pkg::ST_RESP;
                     end
                  end
                  hclb_pkg::KIND_QLEVEL: begin
                     if (req_data.value <= 9'(hclb_pkg::MAX_LEVEL)) begin
                        ans_in = ANSWER_W'(lc_ff[req_data.value[LEVEL_W-1:0]]);
                     end else begin
                        ans_in = '0;
                     end
                     state_in = hclb_pkg::ST_RESP;
                  end
                  hclb_pkg::KIND_CLEAR: begin
                     byte_total_in = '0;
                     maxlev_in     = '0;
                     distinct_in   = '0;
                     ovf_in        = 1'b0;
                     for (int i = 0; i <= hclb_pkg::MAX_LEVEL; i++) begin
                        lc_in[i] = '0;
                     end
                     idx_in   = '0;
                     state_in = hclb_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         hclb_pkg::ST_DATA_WR: begin
            if (hist_rd == '1) begin
               ovf_in = 1'b1;
            end else begin
               hist_we = 1'b1;
               hist_wa = SYM_AW'(byte_ff);
               hist_wd = hist_rd + 1'b1;
            end
            state_in = hclb_pkg::ST_IDLE;
         end

         hclb_pkg::ST_QLEN: begin
            ans_in   = ANSWER_W'(dep_rd);
            state_in = hclb_pkg::ST_RESP;
         end

         // symbols of nonzero weight, 256 down to 0, go into heap slots 1..used
         hclb_pkg::ST_LOAD_RD: begin
            hist_re  = 1'b1;
            state_in = hclb_pkg::ST_LOAD_WR;
         end

         hclb_pkg::ST_LOAD_WR: begin
            par_we = 1'b1;
            if (load_w != '0) begin
               top_heap_req.wr_en   = 1'b1;
               top_heap_req.wr_addr = used_load;
               top_heap_req.wr_data = '{weight: load_w, node: idx_ff};
            end
            used_in = used_load;
            if (idx_ff == '0) begin
               distinct_in = 9'(used_load - 1'b1);
               idx_in      = NODE_AW'(used_load >> 1);
               state_in    = hclb_pkg::ST_HEAPIFY;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = hclb_pkg::ST_LOAD_RD;
            end
         end

         hclb_pkg::ST_HEAPIFY: begin
            if (idx_ff != '0) begin
               sift_start = 1'b1;
               sift_pos   = idx_ff[HEAP_AW-1:0];
               state_in   = hclb_pkg::ST_HEAPIFY_WAIT;
            end else begin
               next_in  = NODE_AW'(hclb_pkg::EOB_SYM);
               state_in = hclb_pkg::ST_MERGE;
            end
         end

         hclb_pkg::ST_HEAPIFY_WAIT: begin
            if (sift_done) begin
               idx_in   = idx_ff - 1'b1;
               state_in = hclb_pkg::ST_HEAPIFY;
            end
         end

         hclb_pkg::ST_MERGE: begin
            if (used_ff > HEAP_AW'(1)) begin
               next_in              = next_ff + 1'b1;
               top_heap_req.rd_en   = 1'b1;
               top_heap_req.rd_addr = HEAP_AW'(1);
               state_in             = hclb_pkg::ST_MERGE_FIRST;
            end else begin
               // root has no parent
               par_we    = 1'b1;
               par_wa    = next_ff;
               idx_in    = next_ff;
               bits_in   = '0;
               maxlev_in = '0;
               for (int i = 0; i <= hclb_pkg::MAX_LEVEL; i++) begin
                  lc_in[i] = '0;
               end
               state_in = hclb_pkg::ST_DEPTH_RD;
            end
         end

         hclb_pkg::ST_MERGE_FIRST: begin
            par_we               = 1'b1;
            par_wa               = heap_rd.node;
            par_wd               = next_ff;
            first_in             = heap_rd.weight;
            top_heap_req.rd_en   = 1'b1;
            top_heap_req.rd_addr = used_ff;
            state_in             = hclb_pkg::ST_MERGE_LAST;
         end

         hclb_pkg::ST_MERGE_LAST: begin
            top_heap_req.wr_en   = 1'b1;
            top_heap_req.wr_addr = HEAP_AW'(1);
            top_heap_req.wr_data = heap_rd;
            used_in              = used_ff - 1'b1;
            sift_start           = 1'b1;
            sift_used            = used_ff - 1'b1;
            state_in             = hclb_pkg::ST_SIFT_A;
         end

         hclb_pkg::ST_SIFT_A: begin
            if (sift_done) begin
               state_in = hclb_pkg::ST_MERGE_RD;
            end
         end

         hclb_pkg::ST_MERGE_RD: begin
            top_heap_req.rd_en   = 1'b1;
            top_heap_req.rd_addr = HEAP_AW'(1);
            state_in             = hclb_pkg::ST_MERGE_JOIN;
         end

         hclb_pkg::ST_MERGE_JOIN: begin
            par_we               = 1'b1;
            par_wa               = heap_rd.node;
            par_wd               = next_ff;
            top_heap_req.wr_en   = 1'b1;
            top_heap_req.wr_addr = HEAP_AW'(1);
            top_heap_req.wr_data = '{weight: heap_rd.weight + first_ff, node: next_ff};
            sift_start           = 1'b1;
            state_in             = hclb_pkg::ST_SIFT_B;
         end

         hclb_pkg::ST_SIFT_B: begin
            if (sift_done) begin
               state_in = hclb_pkg::ST_MERGE;
            end
         end

         // nodes are walked from the root down; a parent always has a higher index
         hclb_pkg::ST_DEPTH_RD: begin
            par_re   = 1'b1;
            state_in = hclb_pkg::ST_DEPTH_PAR;
         end

         hclb_pkg::ST_DEPTH_PAR: begin
            if (par_rd == '0) begin
               dval_in  = '0;
               state_in = hclb_pkg::ST_DEPTH_WR;
            end else begin
               dep_re   = 1'b1;
               dep_ra   = par_rd;
               state_in = hclb_pkg::ST_DEPTH_GET;
            end
         end

         hclb_pkg::ST_DEPTH_GET: begin
            dval_in  = dep_rd + 1'b1;
            state_in = hclb_pkg::ST_DEPTH_WR;
         end

         hclb_pkg::ST_DEPTH_WR: begin
            dep_we = 1'b1;
            dep_wd = dval_ff;
            if (idx_ff < NODE_AW'(hclb_pkg::NSYM)) begin
               if (dval_ff <= DEPTH_W'(hclb_pkg::MAX_LEVEL)) begin
                  lc_in[dval_ff[LEVEL_W-1:0]] = lc_ff[dval_ff[LEVEL_W-1:0]] + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (9'(dval_ff) > maxlev_ff) begin
                  maxlev_in = 9'(dval_ff);
               end
            end
            if (idx_ff < NODE_AW'(hclb_pkg::EOB_SYM)) begin
               hist_re  = 1'b1;
               state_in = hclb_pkg::ST_DEPTH_MUL;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = hclb_pkg::ST_DEPTH_RD;
            end
         end

         hclb_pkg::ST_DEPTH_MUL: begin
            prod_in  = dval_ff * hist_rd;
            state_in = hclb_pkg::ST_DEPTH_ACC;
         end

         hclb_pkg::ST_DEPTH_ACC: begin
            bits_in = bits_ff + BITS_W'(prod_ff);
            if (idx_ff == '0) begin
               state_in = hclb_pkg::ST_SIZE;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = hclb_pkg::ST_DEPTH_RD;
            end
         end

         hclb_pkg::ST_SIZE: begin
            if (size_full[SIZE_W-1:ANSWER_W] != '0) begin
               ans_in = '1;
               ovf_in = 1'b1;
            end else begin
               ans_in = size_full[ANSWER_W-1:0];
            end
            state_in = hclb_pkg::ST_RESP;
         end

         hclb_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{answer: ans_ff, max_level: maxlev_ff,
                                distinct: distinct_ff, total_bytes: byte_total_ff,
                                overflow: ovf_ff};
               state_in     = hclb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = hclb_pkg::ST_IDLE;
         end
      endcase
   end

   `HCLB_ASSERT_SAME(a_sift_owns_heap, sift_heap_req.wr_en || sift_heap_req.rd_en, sift_sel, "heap RAM access by sift unit outside a sift wait")
   `HCLB_ASSERT_NEXT(a_ovf_sticky, ovf_ff && !(req_accept && req_data.kind == hclb_pkg::KIND_CLEAR), ovf_ff, "overflow dropped without a clear item")
   `HCLB_ASSERT_NEXT(a_merge_shrinks, state_ff == hclb_pkg::ST_MERGE_LAST, used_ff == $past(used_ff) - 1'b1, "heap size did not shrink on merge")

endmodule

// File: sv/hclb_ram.sv
// ----------------------------------------------------------------------------
// hclb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hclb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: sv/hclb_sift.sv
// ----------------------------------------------------------------------------
// hclb_sift
// Binary min-heap sift-down sequencer; at most one heap RAM access per cycle.
// ----------------------------------------------------------------------------
module hclb_sift (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [hclb_pkg::HEAP_AW-1:0]   pos,
   input  logic [hclb_pkg::HEAP_AW-1:0]   used,
   output logic                           done,
   output hclb_pkg::heap_req_type         heap_req,
   input  hclb_pkg::heap_entry_type       heap_rd
);

   hclb_pkg::sift_state_type           state_ff, state_in;
   logic [hclb_pkg::HEAP_AW-1:0]       pos_ff, pos_in;
   logic [hclb_pkg::HEAP_AW-1:0]       used_ff, used_in;
   logic [hclb_pkg::HEAP_AW-1:0]       k_ff, k_in;
   hclb_pkg::heap_entry_type           cur_ff, cur_in;
   hclb_pkg::heap_entry_type           cand_ff, cand_in;
   logic [hclb_pkg::HEAP_AW-1:0]       half;
   logic [hclb_pkg::HEAP_AW-1:0]       left;

   assign half = used_ff >> 1;
   assign left = {pos_ff[hclb_pkg::HEAP_AW-2:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hclb_pkg::SF_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      used_ff <= used_in;
      k_ff    <= k_in;
      cur_ff  <= cur_in;
      cand_ff <= cand_in;
   end

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      used_in  = used_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      cand_in  = cand_ff;
      done     = 1'b0;
      heap_req = '0;
      heap_req.wr_data = cur_ff;
      unique case (state_ff)
         hclb_pkg::SF_IDLE: begin
            if (start) begin
               pos_in   = pos;
               used_in  = used;
               state_in = hclb_pkg::SF_RD;
            end
         end
         hclb_pkg::SF_RD: begin
            heap_req.rd_en   = 1'b1;
            heap_req.rd_addr = pos_ff;
            state_in         = hclb_pkg::SF_LDW;
         end
         hclb_pkg::SF_LDW: begin
            cur_in   = heap_rd;
            state_in = hclb_pkg::SF_CHK;
         end
         hclb_pkg::SF_CHK: begin
            if (pos_ff <= half) begin
               heap_req.rd_en   = 1'b1;
               heap_req.rd_addr = left;
               k_in             = left;
               state_in         = hclb_pkg::SF_K0;
            end else begin
               heap_req.wr_en   = 1'b1;
               heap_req.wr_addr = pos_ff;
               done             = 1'b1;
               state_in         = hclb_pkg::SF_IDLE;
            end
         end
         hclb_pkg::SF_K0: begin
            cand_in = heap_rd;
            if (k_ff < used_ff) begin
               heap_req.rd_en   = 1'b1;
               heap_req.rd_addr = k_ff + 1'b1;
               state_in         = hclb_pkg::SF_K1;
            end else begin
               state_in = hclb_pkg::SF_DEC;
            end
         end
         hclb_pkg::SF_K1: begin
            // right child wins only when strictly lighter
            if (cand_ff.weight > heap_rd.weight) begin
               cand_in = heap_rd;
               k_in    = k_ff + 1'b1;
            end
            state_in = hclb_pkg::SF_DEC;
         end
         hclb_pkg::SF_DEC: begin
            heap_req.wr_en   = 1'b1;
            heap_req.wr_addr = pos_ff;
            if (cur_ff.weight < cand_ff.weight) begin
               done     = 1'b1;
               state_in = hclb_pkg::SF_IDLE;
            end else begin
               heap_req.wr_data = cand_ff;
               pos_in           = k_ff;
               state_in         = hclb_pkg::SF_CHK;
            end
         end
         default: begin
            state_in = hclb_pkg::SF_IDLE;
         end
      endcase
   end

endmodule

// File: tb/huffman_code_length_builder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_length_builder_checker
// Watches the request, response and CSR channels, keeps its own histogram
// and heap-based tree build, and compares every response field by field.
// ----------------------------------------------------------------------------
module huffman_code_length_builder_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hclb_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hclb_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                pending
);

   localparam longint unsigned SIZE_MAX = (64'd1 << hclb_pkg::ANSWER_W) - 1;

   bit              lim_en;
   bit [31:0]       lim_bytes;
   bit [31:0]       hist [hclb_pkg::NSYM];
   bit [8:0]        len_tab [hclb_pkg::NSYM];
   bit [8:0]        lvl_tab [hclb_pkg::MAX_LEVEL+1];
   bit [31:0]       n_bytes;
   longint unsigned out_size;
   bit [8:0]        deepest;
   bit [8:0]        n_distinct;
   bit              ovf;

   longint unsigned hw [hclb_pkg::HEAP_SLOTS];
   int              hn [hclb_pkg::HEAP_SLOTS];
   int              par [hclb_pkg::NODE_SLOTS];

   hclb_pkg::rsp_type expected_rsp [$];

   assign pending = expected_rsp.size();

   function automatic void clear_tables();
      foreach (hist[i]) hist[i] = '0;
      foreach (len_tab[i]) len_tab[i] = '0;
      foreach (lvl_tab[i]) lvl_tab[i] = '0;
      n_bytes = '0;
      out_size = 0;
      deepest = '0;
      n_distinct = '0;
      ovf = 1'b0;
   endfunction

   function automatic void sift_down(int pos, int used);
      longint unsigned w;
      int nd, k;
      w = hw[pos];
      nd = hn[pos];
      while (pos <= used / 2) begin
         k = 2 * pos;
         if (k < used && hw[k] > hw[k+1]) k++;
         if (w < hw[k]) break;
         hw[pos] = hw[k];
         hn[pos] = hn[k];
         pos = k;
      end
      hw[pos] = w;
      hn[pos] = nd;
   endfunction

   function automatic void build_lengths();
      int used, nxt, d, p, g;
      longint unsigned w, first, bits;
      foreach (par[i]) par[i] = 0;
      used = 0;
      for (int i = hclb_pkg::NSYM - 1; i >= 0; i--) begin
         w = (i == hclb_pkg::EOB_SYM) ? 64'd1 : 64'(hist[i]) * 2;
         if (w > 0) begin
            used++;
            hw[used] = w;
            hn[used] = i;
         end
      end
      n_distinct = 9'(used - 1);
      for (int i = used / 2; i >= 1; i--) sift_down(i, used);
      nxt = hclb_pkg::EOB_SYM;
      while (used > 1) begin
         nxt++;
         par[hn[1]] = nxt;
         first = hw[1];
         hw[1] = hw[used];
         hn[1] = hn[used];
         used--;
         sift_down(1, used);
         par[hn[1]] = nxt;
         hn[1] = nxt;
         hw[1] += first;
         sift_down(1, used);
      end
      par[nxt] = 0;
      foreach (lvl_tab[i]) lvl_tab[i] = '0;
      deepest = '0;
      bits = 0;
      for (int i = 0; i < hclb_pkg::NSYM; i++) begin
         d = 0;
         g = 0;
         p = par[i];
         while (p != 0 && p < hclb_pkg::NODE_SLOTS && g < hclb_pkg::NODE_SLOTS) begin
            d++;
            g++;
            p = par[p];
         end
         len_tab[i] = 9'(d);
         if (d <= hclb_pkg::MAX_LEVEL) lvl_tab[d]++;
         else ovf = 1'b1;
         if (d > deepest) deepest = 9'(d);
         if (i != hclb_pkg::EOB_SYM) bits += 64'(d) * hist[i];
      end
      out_size = bits / 8 + ((bits % 8) != 0);
      if (out_size > SIZE_MAX) begin
         out_size = SIZE_MAX;
         ovf = 1'b1;
      end
   endfunction

   function automatic void apply_item(hclb_pkg::req_type it);
      longint unsigned ans;
      hclb_pkg::rsp_type r;
      case (it.kind)
         hclb_pkg::KIND_DATA: begin
            if (lim_en && n_bytes >= lim_bytes) return;
            if (n_bytes == 32'hFFFF_FFFF) ovf = 1'b1;
            else n_bytes++;
            if (hist[it.value[7:0]] == 32'hFFFF_FFFF) ovf = 1'b1;
            else hist[it.value[7:0]]++;
            return;
         end
         hclb_pkg::KIND_BUILD: begin
            build_lengths();
            ans = out_size;
         end
         hclb_pkg::KIND_QLEN:
            ans = (it.value < hclb_pkg::NSYM) ? len_tab[it.value] : 0;
         hclb_pkg::KIND_QLEVEL:
            ans = (it.value <= hclb_pkg::MAX_LEVEL) ? lvl_tab[it.value] : 0;
         hclb_pkg::KIND_CLEAR: begin
            clear_tables();
            return;
         end
         default: return;
      endcase
      r.answer = ans[hclb_pkg::ANSWER_W-1:0];
      r.max_level = deepest;
      r.distinct = n_distinct;
      r.total_bytes = n_bytes;
      r.overflow = ovf;
      expected_rsp.push_back(r);
   endfunction

   always @(posedge clock) begin
      hclb_pkg::rsp_type e;
      if (reset) begin
         lim_en <= 1'b0;
         lim_bytes <= '0;
         clear_tables();
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == hclb_pkg::CSR_LIMIT_ENABLE) lim_en = csr_wdata[0];
            else if (csr_index == hclb_pkg::CSR_BYTE_LIMIT) lim_bytes = csr_wdata;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("response item with nothing expected");
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.answer !== e.answer) begin
                  $error("answer: expected %0d, got %0d", e.answer, rsp_data.answer);
                  fail_count++;
               end
               if (rsp_data.max_level !== e.max_level) begin
                  $error("max_level: expected %0d, got %0d", e.max_level, rsp_data.max_level);
                  fail_count++;
               end
               if (rsp_data.distinct !== e.distinct) begin
                  $error("distinct: expected %0d, got %0d", e.distinct, rsp_data.distinct);
                  fail_count++;
               end
               if (rsp_data.total_bytes !== e.total_bytes) begin
                  $error("total_bytes: expected %0d, got %0d", e.total_bytes,
                         rsp_data.total_bytes);
                  fail_count++;
               end
               if (rsp_data.overflow !== e.overflow) begin
                  $error("overflow: expected %0d, got %0d", e.overflow, rsp_data.overflow);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) apply_item(req_data);
      end
   end

endmodule

// File: tb/huffman_code_length_builder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_code_length_builder_tb
// Drives byte, build, query and clear items plus CSR settings into the
// builder with random idling; a checker beside the block does the compare.
// ----------------------------------------------------------------------------
module huffman_code_length_builder_tb;

   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int         CYCLE_LIMIT      = 20_000_000;
   localparam int         SETTLE_CYCLES    = 300;
   localparam int         RANDOM_ITEMS     = 1300;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   hclb_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   hclb_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [1:0]        csr_index;
   logic [31:0]       csr_wdata;
   int                fail_count;
   int                pending;
   int                cycles;
   bit                quiet;
   bit                calm;
   int                stall_left;

   huffman_code_length_builder i_dut (.*);

   huffman_code_length_builder_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(logic [2:0] k, logic [8:0] v);
      req_data <= '{kind: k, value: v};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 60);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int done, alpha, base, r;
      longint unsigned fa, fb, ft;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cycles = 0;
      quiet = 1'b0;
      calm = 1'b0;
      stall_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, masking, out-of-range queries, empty build
      send(hclb_pkg::KIND_BUILD, 9'd0);
      send(hclb_pkg::KIND_DATA, 9'd0);
      send(hclb_pkg::KIND_DATA, 9'd255);
      send(hclb_pkg::KIND_DATA, 9'd256);
      send(hclb_pkg::KIND_DATA, 9'd511);
      send(hclb_pkg::KIND_DATA, 9'd170);
      send(hclb_pkg::KIND_BUILD, 9'd0);
      send(hclb_pkg::KIND_BUILD, 9'd0);
      send(hclb_pkg::KIND_QLEN, 9'd0);
      send(hclb_pkg::KIND_QLEN, 9'd255);
      send(hclb_pkg::KIND_QLEN, 9'd256);
      send(hclb_pkg::KIND_QLEN, 9'd511);
      send(hclb_pkg::KIND_QLEVEL, 9'd0);
      send(hclb_pkg::KIND_QLEVEL, 9'd2);
      send(hclb_pkg::KIND_QLEVEL, 9'd24);
      send(hclb_pkg::KIND_QLEVEL, 9'd25);
      send(KIND_SPARE_FIRST, 9'd85);
      send(KIND_SPARE_LAST, 9'd1);
      send(hclb_pkg::KIND_CLEAR, 9'd0);
      send(hclb_pkg::KIND_QLEN, 9'd255);
      send(hclb_pkg::KIND_BUILD, 9'd0);
      settle();
      // byte limit reached mid-stream
      csr_write(hclb_pkg::CSR_LIMIT_ENABLE, 32'd1);
      csr_write(hclb_pkg::CSR_BYTE_LIMIT, 32'd3);
      repeat (3) send(hclb_pkg::KIND_DATA, 9'd7);
      send(hclb_pkg::KIND_DATA, 9'd9);
      send(hclb_pkg::KIND_BUILD, 9'd0);

      done = 0;
      while (done < RANDOM_ITEMS) begin
         settle();
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 1)) csr_write(hclb_pkg::CSR_LIMIT_ENABLE, $urandom);
         if ($urandom_range(0, 1)) csr_write(hclb_pkg::CSR_BYTE_LIMIT, pick_limit());
         if ($urandom_range(0, 2) == 0) send(hclb_pkg::KIND_CLEAR, 9'($urandom_range(0, 511)));
         alpha = $urandom_range(1, 20);
         base = $urandom_range(0, 255);
         repeat ($urandom_range(20, 80)) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               send(hclb_pkg::KIND_DATA, 9'((base + $urandom_range(0, alpha - 1)) % 256));
            end else if (r < 60) begin
               send(hclb_pkg::KIND_DATA, 9'($urandom_range(0, 511)));
            end else if (r < 72) begin
               send(hclb_pkg::KIND_QLEN, $urandom_range(0, 3) == 0 ?
                    9'($urandom_range(0, 511)) : 9'((base + $urandom_range(0, 20)) % 257));
            end else if (r < 86) begin
               send(hclb_pkg::KIND_QLEVEL, $urandom_range(0, 4) == 0 ?
                    9'($urandom_range(0, 511)) : 9'($urandom_range(0, 25)));
            end else if (r < 94) begin
               send(hclb_pkg::KIND_BUILD, 9'($urandom_range(0, 511)));
            end else if (r < 98) begin
               send(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
                    9'($urandom_range(0, 511)));
            end else begin
               send(hclb_pkg::KIND_CLEAR, 9'($urandom_range(0, 511)));
            end
            done++;
         end
         send(hclb_pkg::KIND_BUILD, 9'd0);
         send(hclb_pkg::KIND_QLEVEL, 9'($urandom_range(0, 8)));
      end

      // last part: no idling; Fibonacci counts give a deep, skewed tree
      settle();
      quiet = 1'b1;
      csr_write(hclb_pkg::CSR_LIMIT_ENABLE, 32'd0);
      csr_write(hclb_pkg::CSR_BYTE_LIMIT, 32'hFFFF_FFFF);
      send(hclb_pkg::KIND_CLEAR, 9'd0);
      fa = 1;
      fb = 1;
      for (int s = 1; s <= 12; s++) begin
         repeat (fa) send(hclb_pkg::KIND_DATA, 9'(s));
         ft = fa + fb;
         fa = fb;
         fb = ft;
      end
      send(hclb_pkg::KIND_BUILD, 9'd0);
      for (int s = 0; s <= 27; s++) send(hclb_pkg::KIND_QLEN, 9'(s));
      send(hclb_pkg::KIND_QLEN, 9'd256);
      for (int d = 0; d <= hclb_pkg::MAX_LEVEL + 1; d++) send(hclb_pkg::KIND_QLEVEL, 9'(d));
      settle();

      if (fail_count == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
